// ----- rtl/core/hms_countdown_timer_unit_macros.svh -----
// Assertion helpers for the countdown timer. Each macro expects a clk and
// rst in scope and checks only outside reset.
`ifndef HMS_COUNTDOWN_TIMER_UNIT_MACROS_SVH
`define HMS_COUNTDOWN_TIMER_UNIT_MACROS_SVH

// Same-cycle implication.
`define HCT_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define HCT_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- rtl/core/hct_pkg.sv -----
package hct_pkg;

  // Command codes on the func field
  localparam logic [2:0] FN_TICK  = 3'd0;
  localparam logic [2:0] FN_START = 3'd1;
  localparam logic [2:0] FN_STOP  = 3'd2;
  localparam logic [2:0] FN_SET   = 3'd3;
  localparam logic [2:0] FN_READ  = 3'd4;
  localparam logic [2:0] FN_NOP   = 3'd7;

  // Countdown arithmetic
  localparam logic [5:0] SPLIT_STEP   = 6'd3;
  localparam logic [5:0] SPLIT_REFILL = 6'd57;
  localparam logic [5:0] FIELD_MAX    = 6'd59;

  // Classified command as it travels from front to back
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] splits;
  } cmd_t;

  // Queue occupancy seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [5:0] clamp59(input logic [5:0] v);
    return (v > FIELD_MAX) ? FIELD_MAX : v;
  endfunction

endpackage

// ----- rtl/core/hct_front.sv -----
module hct_front
  import hct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [7:0] load_hours,
  input  logic [5:0] load_minutes,
  input  logic [5:0] load_seconds,
  input  logic [5:0] load_splits,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       push_ready
);

  logic held;
  cmd_t held_cmd;
  cmd_t decoded;
  logic take;

  // Classify the command and clamp the minute, second and split load fields
  always_comb begin
    decoded.op = func;
    if (!(func inside {FN_TICK, FN_START, FN_STOP, FN_SET, FN_READ})) begin
      decoded.op = FN_NOP;
    end
    decoded.hours   = load_hours;
    decoded.minutes = clamp59(load_minutes);
    decoded.seconds = clamp59(load_seconds);
    decoded.splits  = clamp59(load_splits);
  end

  assign push     = held;
  assign push_cmd = held_cmd;
  assign in_stall = held && !push_ready;
  assign take     = in_valid && !in_stall;

  // Hold one classified beat until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_cmd <= decoded;
    end
  end

endmodule

// ----- rtl/core/hct_queue.sv -----
module hct_queue
  import hct_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  output logic          push_ready,
  input  logic          pop,
  output cmd_t          pop_cmd,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign push_ready   = !status.full;
  assign do_push      = push && push_ready;
  assign do_pop       = pop && !status.empty;
  assign pop_cmd      = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/hct_back.sv -----
module hct_back
  import hct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_avail,
  input  cmd_t       cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       running,
  output logic [7:0] hours_now,
  output logic [5:0] minutes_now,
  output logic [5:0] seconds_now,
  output logic [5:0] splits_now,
  output logic       update_pending,
  output logic       expired_pending,
  output logic       start_accepted
);

  logic       run_flag;
  logic [7:0] hour_count;
  logic [5:0] minute_count;
  logic [5:0] second_count;
  logic [5:0] split_count;
  logic       ev_update;
  logic       ev_expired;

  logic       run_flag_next;
  logic [7:0] hour_count_next;
  logic [5:0] minute_count_next;
  logic [5:0] second_count_next;
  logic [5:0] split_count_next;
  logic       ev_update_next;
  logic       ev_expired_next;
  logic       accepted;
  logic       time_nonzero;

  assign pop = cmd_avail && (!out_valid || !out_stall);
  assign time_nonzero = (hour_count != '0) || (minute_count != '0) ||
                        (second_count != '0) || (split_count != '0);

  // Execute one command against the timer state
  always_comb begin
    run_flag_next     = run_flag;
    hour_count_next   = hour_count;
    minute_count_next = minute_count;
    second_count_next = second_count;
    split_count_next  = split_count;
    ev_update_next    = ev_update;
    ev_expired_next   = ev_expired;
    accepted          = 1'b0;
    case (cmd.op)
      FN_TICK: begin
        if (run_flag) begin
          ev_update_next = 1'b1;
          if (split_count >= SPLIT_STEP) begin
            split_count_next = split_count - SPLIT_STEP;
          end else if (second_count != '0) begin
            split_count_next  = split_count + SPLIT_REFILL;
            second_count_next = second_count - 1'b1;
          end else if (minute_count != '0) begin
            split_count_next  = split_count + SPLIT_REFILL;
            second_count_next = FIELD_MAX;
            minute_count_next = minute_count - 1'b1;
          end else if (hour_count != '0) begin
            split_count_next  = split_count + SPLIT_REFILL;
            second_count_next = FIELD_MAX;
            minute_count_next = FIELD_MAX;
            hour_count_next   = hour_count - 1'b1;
          end else begin
            split_count_next = '0;
            ev_expired_next  = 1'b1;
            run_flag_next    = 1'b0;
          end
        end
      end
      FN_START: begin
        if (time_nonzero) begin
          run_flag_next = 1'b1;
          accepted      = 1'b1;
        end
      end
      FN_STOP: begin
        run_flag_next = 1'b0;
      end
      FN_SET: begin
        if (!run_flag) begin
          hour_count_next   = cmd.hours;
          minute_count_next = cmd.minutes;
          second_count_next = cmd.seconds;
          split_count_next  = cmd.splits;
        end
      end
      default: begin
      end
    endcase
  end

  // Update timer state and drop events on read
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag     <= 1'b0;
      hour_count   <= '0;
      minute_count <= '0;
      second_count <= '0;
      split_count  <= '0;
      ev_update    <= 1'b0;
      ev_expired   <= 1'b0;
    end else if (pop) begin
      run_flag     <= run_flag_next;
      hour_count   <= hour_count_next;
      minute_count <= minute_count_next;
      second_count <= second_count_next;
      split_count  <= split_count_next;
      ev_update    <= (cmd.op == FN_READ) ? 1'b0 : ev_update_next;
      ev_expired   <= (cmd.op == FN_READ) ? 1'b0 : ev_expired_next;
    end
  end

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      running         <= run_flag_next;
      hours_now       <= hour_count_next;
      minutes_now     <= minute_count_next;
      seconds_now     <= second_count_next;
      splits_now      <= split_count_next;
      update_pending  <= ev_update_next;
      expired_pending <= ev_expired_next;
      start_accepted  <= accepted;
    end
  end

endmodule

// ----- rtl/core/hms_countdown_timer_unit.sv -----
// Countdown timer over hours, minutes, seconds and sixtieth-second splits.
// Input channel: in_valid/in_stall with one command per beat on func and the
// load_* fields. Output channel: out_valid/out_stall with one result beat per
// command, carrying the run flag, the remaining time, the event flags and the
// start acknowledge.
// A command passes a classify register, a small command queue and the
// execute stage with its result register on its way from input beat to
// result beat. One command per cycle is sustained when nothing stalls; the
// execute stage updates all timer state together as it pops a command.
// A stalled result holds its beat; commands keep flowing into the queue
// until it fills (QUEUE_DEPTH entries plus the classify register), then
// in_stall rises.
// Reset (rst, synchronous) clears the time, the run flag, the events and
// all pending beats; the block takes commands in the cycle after reset.
`include "hms_countdown_timer_unit_macros.svh"

module hms_countdown_timer_unit
  import hct_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2  // 2 to 16 entries
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [7:0] load_hours,
  input  logic [5:0] load_minutes,
  input  logic [5:0] load_seconds,
  input  logic [5:0] load_splits,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       running,
  output logic [7:0] hours_now,
  output logic [5:0] minutes_now,
  output logic [5:0] seconds_now,
  output logic [5:0] splits_now,
  output logic       update_pending,
  output logic       expired_pending,
  output logic       start_accepted
);

  logic          push;
  logic          push_ready;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          pop_cmd;
  queue_status_t q_status;

  // Accept and classify commands
  hct_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .load_hours   (load_hours),
    .load_minutes (load_minutes),
    .load_seconds (load_seconds),
    .load_splits  (load_splits),
    .push         (push),
    .push_cmd     (push_cmd),
    .push_ready   (push_ready)
  );

  // Decouple front and back
  hct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .status     (q_status)
  );

  // Execute commands and register results
  hct_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_avail       (!q_status.empty),
    .cmd             (pop_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .running         (running),
    .hours_now       (hours_now),
    .minutes_now     (minutes_now),
    .seconds_now     (seconds_now),
    .splits_now      (splits_now),
    .update_pending  (update_pending),
    .expired_pending (expired_pending),
    .start_accepted  (start_accepted)
  );

  `HCT_ASSERT_NOW(a_pop_not_empty, pop, !q_status.empty, "pop from empty queue")
  `HCT_ASSERT_NOW(a_push_not_full, push && push_ready, !q_status.full, "push into full queue")
  `HCT_ASSERT_NOW(a_start_runs, out_valid && start_accepted, running, "accepted start not running")
  `HCT_ASSERT_NEXT(a_pop_gives_beat, pop, out_valid, "executed command lost its result beat")

endmodule

// ----- sim/hms_countdown_timer_unit_tb.sv -----
module hms_countdown_timer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hct_pkg::*;

  // Spare command codes that the block must ignore
  localparam logic [2:0] FN_SPARE5 = 3'd5;
  localparam logic [2:0] FN_SPARE6 = 3'd6;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTED  = 30;

  typedef struct packed {
    logic       running;
    logic [7:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] splits;
    logic       update_ev;
    logic       expired_ev;
    logic       start_ok;
  } timer_result_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] func;
  logic [7:0] load_hours;
  logic [5:0] load_minutes;
  logic [5:0] load_seconds;
  logic [5:0] load_splits;
  logic       out_valid;
  logic       out_stall;
  logic       running;
  logic [7:0] hours_now;
  logic [5:0] minutes_now;
  logic [5:0] seconds_now;
  logic [5:0] splits_now;
  logic       update_pending;
  logic       expired_pending;
  logic       start_accepted;

  // Predicted timer state
  logic       tmr_run;
  logic [7:0] tmr_hours;
  logic [5:0] tmr_minutes;
  logic [5:0] tmr_seconds;
  logic [5:0] tmr_splits;
  logic       tmr_update_ev;
  logic       tmr_expired_ev;

  timer_result_t expected_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  items_sent  = 0;
  int  spare_sent  = 0;
  int  rx_hold_req = 0;
  bit  tx_gaps_on  = 1'b1;
  bit  rx_gaps_on  = 1'b1;

  hms_countdown_timer_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .load_hours      (load_hours),
    .load_minutes    (load_minutes),
    .load_seconds    (load_seconds),
    .load_splits     (load_splits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .running         (running),
    .hours_now       (hours_now),
    .minutes_now     (minutes_now),
    .seconds_now     (seconds_now),
    .splits_now      (splits_now),
    .update_pending  (update_pending),
    .expired_pending (expired_pending),
    .start_accepted  (start_accepted)
  );

  // Generate the 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [5:0] limit_to_59(input logic [5:0] v);
    return (v > FIELD_MAX) ? FIELD_MAX : v;
  endfunction

  // Advance the predicted timer by one command and return its result beat
  function automatic timer_result_t timer_next_result(input logic [2:0] op,
                                                      input logic [7:0] hrs,
                                                      input logic [5:0] mins,
                                                      input logic [5:0] secs,
                                                      input logic [5:0] spl);
    timer_result_t res;
    res.start_ok = 1'b0;
    case (op)
      FN_TICK: begin
        if (tmr_run) begin
          tmr_update_ev = 1'b1;
          if (tmr_splits >= SPLIT_STEP) begin
            tmr_splits = tmr_splits - SPLIT_STEP;
          end else if (tmr_seconds != '0) begin
            tmr_splits  = tmr_splits + SPLIT_REFILL;
            tmr_seconds = tmr_seconds - 1'b1;
          end else if (tmr_minutes != '0) begin
            tmr_splits  = tmr_splits + SPLIT_REFILL;
            tmr_seconds = FIELD_MAX;
            tmr_minutes = tmr_minutes - 1'b1;
          end else if (tmr_hours != '0) begin
            tmr_splits  = tmr_splits + SPLIT_REFILL;
            tmr_seconds = FIELD_MAX;
            tmr_minutes = FIELD_MAX;
            tmr_hours   = tmr_hours - 1'b1;
          end else begin
            // Nothing left to borrow: expire and drop to standby
            tmr_splits     = '0;
            tmr_expired_ev = 1'b1;
            tmr_run        = 1'b0;
          end
        end
      end
      FN_START: begin
        if (tmr_hours != '0 || tmr_minutes != '0 || tmr_seconds != '0 ||
            tmr_splits != '0) begin
          tmr_run      = 1'b1;
          res.start_ok = 1'b1;
        end
      end
      FN_STOP: tmr_run = 1'b0;
      FN_SET: begin
        if (!tmr_run) begin
          tmr_hours   = hrs;
          tmr_minutes = limit_to_59(mins);
          tmr_seconds = limit_to_59(secs);
          tmr_splits  = limit_to_59(spl);
        end
      end
      default: ;
    endcase
    res.running    = tmr_run;
    res.hours      = tmr_hours;
    res.minutes    = tmr_minutes;
    res.seconds    = tmr_seconds;
    res.splits     = tmr_splits;
    res.update_ev  = tmr_update_ev;
    res.expired_ev = tmr_expired_ev;
    // Read reports the flags, then clears them
    if (op == FN_READ) begin
      tmr_update_ev  = 1'b0;
      tmr_expired_ev = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (running !== want.running)
          report_mismatch("running", int'(running), int'(want.running));
        if (hours_now !== want.hours)
          report_mismatch("hours_now", int'(hours_now), int'(want.hours));
        if (minutes_now !== want.minutes)
          report_mismatch("minutes_now", int'(minutes_now), int'(want.minutes));
        if (seconds_now !== want.seconds)
          report_mismatch("seconds_now", int'(seconds_now), int'(want.seconds));
        if (splits_now !== want.splits)
          report_mismatch("splits_now", int'(splits_now), int'(want.splits));
        if (update_pending !== want.update_ev)
          report_mismatch("update_pending", int'(update_pending), int'(want.update_ev));
        if (expired_pending !== want.expired_ev)
          report_mismatch("expired_pending", int'(expired_pending), int'(want.expired_ev));
        if (start_accepted !== want.start_ok)
          report_mismatch("start_accepted", int'(start_accepted), int'(want.start_ok));
      end
    end
  end

  // Drive the result stall: random waits per beat, plus long hold-offs on request
  initial begin : rx_driver
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_gaps_on && out_valid && !out_stall) begin
        stall_left = $urandom_range(0, 3);
      end else if (rx_gaps_on && stall_left == 0 && !out_valid &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = 1;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one command beat and predict its result once it is taken
  task automatic send_cmd(input logic [2:0] op, input logic [7:0] hrs, input logic [5:0] mins,
                          input logic [5:0] secs, input logic [5:0] spl);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= op;
    load_hours   <= hrs;
    load_minutes <= mins;
    load_seconds <= secs;
    load_splits  <= spl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(timer_next_result(op, hrs, mins, secs, spl));
    items_sent++;
    if (op > FN_READ) spare_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Commands in standby with a zero time, a spare code and the NOP code
  task automatic test_idle_commands();
    send_cmd(FN_TICK, 8'hff, 6'h3f, 6'h3f, 6'h3f);
    send_cmd(FN_START, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_SPARE5, 8'hff, 6'h3f, 6'h3f, 6'h3f);
    send_cmd(FN_NOP, 8'h00, 6'h00, 6'h00, 6'h00);
  endtask

  // Load above-range values, which clamp to 59 except hours
  task automatic test_set_clamp();
    send_cmd(FN_SET, 8'hff, 6'h3f, 6'h3f, 6'h3f);
  endtask

  // Restart while running, ignored load, borrow from seconds, stop keeps time
  task automatic test_start_stop();
    send_cmd(FN_SET, 8'd0, 6'd0, 6'd2, 6'd1);
    send_cmd(FN_START, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_START, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_SET, 8'd9, 6'd9, 6'd9, 6'd9);
    send_cmd(FN_TICK, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_STOP, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_READ, 8'h00, 6'h00, 6'h00, 6'h00);
  endtask

  // Borrow from hours and from minutes, then run out and expire
  task automatic test_borrow_expiry();
    send_cmd(FN_SET, 8'd1, 6'd0, 6'd0, 6'd2);
    send_cmd(FN_START, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_TICK, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_STOP, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_SET, 8'd0, 6'd1, 6'd0, 6'd1);
    send_cmd(FN_START, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_TICK, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_STOP, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_SET, 8'd0, 6'd0, 6'd0, 6'd4);
    send_cmd(FN_START, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_TICK, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_TICK, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_READ, 8'h00, 6'h00, 6'h00, 6'h00);
  endtask

  // Hold off results for a long stretch while ticks keep coming back to back
  task automatic test_backpressure();
    send_cmd(FN_SET, 8'd0, 6'd0, 6'd5, 6'd0);
    send_cmd(FN_START, 8'h00, 6'h00, 6'h00, 6'h00);
    tx_gaps_on  = 1'b0;
    rx_hold_req = 40;
    repeat (20) send_cmd(FN_TICK, 8'h00, 6'h00, 6'h00, 6'h00);
    send_cmd(FN_READ, 8'h00, 6'h00, 6'h00, 6'h00);
    wait_results_drained();
    tx_gaps_on = 1'b1;
  endtask

  // Mostly countdown sequences with random content, plus noise
  task automatic test_random_traffic();
    int base;
    int kind;
    int mode;
    int n_ticks;
    int r;
    logic [7:0] h;
    logic [5:0] m;
    logic [5:0] s;
    logic [5:0] sp;
    base = items_sent - spare_sent;
    while (items_sent - spare_sent - base < RANDOM_ITEMS) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // Pick a countdown that reaches a chosen borrow depth
        mode = $urandom_range(0, 3);
        case (mode)
          0: begin
            h = 8'd0; m = 6'd0; s = 6'($urandom_range(0, 2));
            sp = 6'($urandom_range(0, 63));
          end
          1: begin
            h = 8'd0; m = 6'($urandom_range(1, 2)); s = 6'd0;
            sp = 6'($urandom_range(0, 5));
          end
          2: begin
            h = 8'($urandom_range(1, 255)); m = 6'd0; s = 6'd0;
            sp = 6'($urandom_range(0, 5));
          end
          default: begin
            h = 8'($urandom_range(0, 255)); m = 6'($urandom_range(0, 63));
            s = 6'($urandom_range(0, 63)); sp = 6'($urandom_range(0, 63));
          end
        endcase
        send_cmd(FN_SET, h, m, s, sp);
        send_cmd(FN_START, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        n_ticks = $urandom_range(1, 48);
        repeat (n_ticks) begin
          r = $urandom_range(0, 15);
          if (r == 0)
            send_cmd(FN_READ, 8'h00, 6'h00, 6'h00, 6'h00);
          else if (r == 1)
            send_cmd(FN_SET, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                     6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
          else if (r == 2)
            send_cmd(FN_START, 8'h00, 6'h00, 6'h00, 6'h00);
          else
            send_cmd(FN_TICK, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                     6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        end
        if ($urandom_range(0, 1) == 0)
          send_cmd(FN_STOP, 8'h00, 6'h00, 6'h00, 6'h00);
        send_cmd(FN_READ, 8'h00, 6'h00, 6'h00, 6'h00);
      end else begin
        // Noise: any code with arbitrary fields
        repeat ($urandom_range(1, 8)) begin
          send_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)));
        end
      end
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end
    rx_gaps_on = 1'b1;
    tx_gaps_on = 1'b1;
  endtask

  // Mirror the reset state of the block, then reset it and run the tests
  initial begin
    tmr_run        = 1'b0;
    tmr_hours      = '0;
    tmr_minutes    = '0;
    tmr_seconds    = '0;
    tmr_splits     = '0;
    tmr_update_ev  = 1'b0;
    tmr_expired_ev = 1'b0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    func         <= FN_TICK;
    load_hours   <= '0;
    load_minutes <= '0;
    load_seconds <= '0;
    load_splits  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_commands();
    test_set_clamp();
    test_start_stop();
    test_borrow_expiry();
    wait_results_drained();
    test_backpressure();
    send_cmd(FN_SPARE6, 8'h5a, 6'h2a, 6'h15, 6'h3c);
    test_random_traffic();

    // Drain, then let the pipeline settle
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
